// ----- rtl/assert_macros.svh -----
// Assertion macros used by the stack machine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SMC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on every clock edge outside reset.
`define SMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/smc_pkg.sv -----
// Types, constants and helpers of the stack machine core.
package smc_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int DATA_CELLS  = 256;
   localparam int WORD_BITS   = 32;

   localparam int OPCODE_BITS = 3;
   localparam int IMM_BITS    = 32;
   localparam int CELL_BITS   = 8;
   localparam int STATUS_BITS = 2;
   localparam int TOP_BITS    = 32;
   localparam int COUNT_BITS  = 5;

   localparam int ADDR_BITS  = $clog2(DATA_CELLS);
   localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [DEPTH_BITS-1:0] depth_type;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_LDC = 3'd0,
      OP_ST  = 3'd1,
      OP_LD  = 3'd2,
      OP_ADD = 3'd3,
      OP_SUB = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2
   } status_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } mem_req_type;

   // Low TOP_BITS of a word, sign-extended when the word is narrower.
   function automatic logic [TOP_BITS-1:0] word_to_top(input word_type w);
      return TOP_BITS'(signed'(w));
   endfunction

   // Immediate sign-extended or truncated to the word width.
   function automatic word_type imm_to_word(input logic signed [IMM_BITS-1:0] imm);
      return WORD_BITS'(imm);
   endfunction

endpackage

// ----- rtl/smc_if.sv -----
// Request and response channel interfaces of the stack machine core.
interface smc_req_if;
   import smc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [OPCODE_BITS-1:0]      opcode;
   logic signed [IMM_BITS-1:0]  immediate;
   logic [CELL_BITS-1:0]        cell_address;

   modport source (output valid, output opcode, output immediate, output cell_address,
                   input ready);
   modport sink (input valid, input opcode, input immediate, input cell_address,
                 output ready);
endinterface

interface smc_rsp_if;
   import smc_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [STATUS_BITS-1:0]      status;
   logic signed [TOP_BITS-1:0]  top_value;
   logic [COUNT_BITS-1:0]       stack_count;

   modport source (output valid, output status, output top_value, output stack_count,
                   input ready);
   modport sink (input valid, input status, input top_value, input stack_count,
                 output ready);
endinterface

// ----- rtl/smc_data_mem.sv -----
// Data memory with per-cell written flags and write-first forwarding.
module smc_data_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  smc_pkg::mem_req_type mem_req,
   output smc_pkg::word_type    rd_data
);
   import smc_pkg::*;

   word_type                mem_ff [DATA_CELLS];
   logic [DATA_CELLS-1:0]   written_ff;
   word_type                rd_raw_ff;
   logic                    rd_written_ff;
   logic                    fwd_ff;
   word_type                fwd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_raw_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            written_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_written_ff <= written_ff[mem_req.rd_addr];
            fwd_ff        <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         fwd_data_ff <= mem_req.wr_data;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (rd_written_ff ? rd_raw_ff : '0);

endmodule

// ----- rtl/stack_machine_core.sv -----
// Stack machine core: executes one decoded instruction per transfer.
// One instruction is taken per cycle unless a held response stalls the input
// register. A request passes through the input register, where it waits while
// the data memory read completes, and then the response register before its
// response can transfer. The stack is a shift register that push, pop and
// add/sub shift in place; a store that is followed directly by a load of the
// same cell is forwarded. Reset clears the stack depth and the per-cell
// written flags at once, so no clearing pass is needed.
`include "assert_macros.svh"

module stack_machine_core (
   input logic       clock,
   input logic       reset,
   smc_req_if.sink   req_chan,
   smc_rsp_if.source rsp_chan
);
   import smc_pkg::*;

   logic                        a_valid_ff;
   opcode_type                  a_op_ff;
   logic signed [IMM_BITS-1:0]  a_imm_ff;
   addr_type                    a_addr_ff;

   word_type                    stack_ff [STACK_DEPTH];
   word_type                    stack_in [STACK_DEPTH];
   depth_type                   depth_ff;
   depth_type                   depth_in;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   status_type                  status_ff;
   status_type                  status_in;
   logic [TOP_BITS-1:0]         top_ff;
   logic [TOP_BITS-1:0]         top_in;
   logic [COUNT_BITS-1:0]       count_ff;

   logic                        req_fire;
   logic                        a_fire;
   logic                        st_ok;
   word_type                    push_word;
   word_type                    alu_word;
   word_type                    mem_rd_data;
   mem_req_type                 mem_req;

   assign a_fire         = a_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !a_valid_ff || a_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      mem_req.rd_en   = req_fire;
      mem_req.rd_addr = ADDR_BITS'(req_chan.cell_address);
      mem_req.wr_en   = a_fire && st_ok;
      mem_req.wr_addr = a_addr_ff;
      mem_req.wr_data = stack_ff[0];
   end

   smc_data_mem u_data_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   assign push_word = (a_op_ff == OP_LDC) ? imm_to_word(a_imm_ff) : mem_rd_data;
   assign alu_word  = (a_op_ff == OP_ADD) ? (stack_ff[0] + stack_ff[1])
                                          : (stack_ff[0] - stack_ff[1]);

   always_comb begin
      stack_in  = stack_ff;
      depth_in  = depth_ff;
      status_in = ST_OK;
      st_ok     = 1'b0;
      case (a_op_ff)
         OP_LDC, OP_LD: begin
            if (depth_ff == DEPTH_BITS'(STACK_DEPTH)) begin
               status_in = ST_OVER;
            end else begin
               for (int i = 1; i < STACK_DEPTH; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               stack_in[0] = push_word;
               depth_in    = depth_ff + 1'b1;
            end
         end
         OP_ST: begin
            if (depth_ff == '0) begin
               status_in = ST_UNDER;
            end else begin
               for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               depth_in = depth_ff - 1'b1;
               st_ok    = 1'b1;
            end
         end
         OP_ADD, OP_SUB: begin
            if (depth_ff < DEPTH_BITS'(2)) begin
               status_in = ST_UNDER;
            end else begin
               for (int i = 1; i < STACK_DEPTH - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               stack_in[0] = alu_word;
               depth_in    = depth_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign top_in       = (depth_in == '0) ? '0 : word_to_top(stack_in[0]);
   assign rsp_valid_in = a_fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= req_fire || (a_valid_ff && !a_fire);
         rsp_valid_ff <= rsp_valid_in;
         if (a_fire) begin
            depth_ff <= depth_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_op_ff   <= opcode_type'(req_chan.opcode);
         a_imm_ff  <= req_chan.immediate;
         a_addr_ff <= ADDR_BITS'(req_chan.cell_address);
      end
      if (a_fire) begin
         stack_ff  <= stack_in;
         status_ff <= status_in;
         top_ff    <= top_in;
         count_ff  <= COUNT_BITS'(depth_in);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.top_value   = top_ff;
   assign rsp_chan.stack_count = count_ff;

   `SMC_ASSERT_IMPL(a_req_only_when_free, clock, reset,
                    req_fire, !a_valid_ff || a_fire)
   `SMC_ASSERT_NEXT(a_error_keeps_depth, clock, reset,
                    a_fire && (status_in != ST_OK), depth_ff == $past(depth_ff))
   `SMC_ASSERT_NEXT(a_store_pops_one, clock, reset,
                    a_fire && st_ok, depth_ff == $past(depth_ff) - 1'b1)

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the stack machine core: directed and random instruction streams.
module tb_top;
   import smc_pkg::*;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1900;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 37;

   typedef struct {
      status_type              status;
      logic [TOP_BITS-1:0]     top_value;
      logic [COUNT_BITS-1:0]   stack_count;
   } machine_view_type;

   logic clock;
   logic reset;

   smc_req_if req_if ();
   smc_rsp_if rsp_if ();

   stack_machine_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow machine state
   logic [WORD_BITS-1:0] shadow_stack [STACK_DEPTH];
   logic [WORD_BITS-1:0] shadow_mem [DATA_CELLS];
   int unsigned          shadow_depth;
   machine_view_type     views_due [$];

   int          idle_pct;
   int          stall_pct;
   int unsigned instr_sent;
   int unsigned error_count;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   function automatic void execute_instr(input logic [OPCODE_BITS-1:0] op,
                                         input logic [IMM_BITS-1:0] imm,
                                         input logic [CELL_BITS-1:0] addr);
      machine_view_type     view;
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
      int unsigned          cell_idx;
      view.status = ST_OK;
      cell_idx = addr % DATA_CELLS;
      case (op)
         OP_LDC, OP_LD: begin
            if (shadow_depth >= STACK_DEPTH) begin
               view.status = ST_OVER;
            end else begin
               shadow_stack[shadow_depth] = (op == OP_LDC) ? WORD_BITS'(signed'(imm))
                                                           : shadow_mem[cell_idx];
               shadow_depth++;
            end
         end
         OP_ST: begin
            if (shadow_depth == 0) begin
               view.status = ST_UNDER;
            end else begin
               shadow_depth--;
               shadow_mem[cell_idx] = shadow_stack[shadow_depth];
            end
         end
         OP_ADD, OP_SUB: begin
            if (shadow_depth < 2) begin
               view.status = ST_UNDER;
            end else begin
               a = shadow_stack[shadow_depth - 1];
               b = shadow_stack[shadow_depth - 2];
               shadow_depth--;
               shadow_stack[shadow_depth - 1] = (op == OP_ADD) ? a + b : a - b;
            end
         end
         default: ;
      endcase
      view.top_value   = (shadow_depth == 0) ? '0
                         : TOP_BITS'(signed'(shadow_stack[shadow_depth - 1]));
      view.stack_count = COUNT_BITS'(shadow_depth);
      views_due.push_back(view);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         execute_instr(req_if.opcode, req_if.immediate, req_if.cell_address);
      end
   end

   always @(posedge clock) begin
      machine_view_type exp_view;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (views_due.size() == 0) begin
            $error("response transfer with nothing expected");
            error_count++;
         end else begin
            exp_view = views_due.pop_front();
            if (rsp_if.status !== exp_view.status) begin
               $error("status: expected %0d, actual %0d", exp_view.status, rsp_if.status);
               error_count++;
            end
            if (rsp_if.top_value !== exp_view.top_value) begin
               $error("top_value: expected %h, actual %h", exp_view.top_value,
                      rsp_if.top_value);
               error_count++;
            end
            if (rsp_if.stack_count !== exp_view.stack_count) begin
               $error("stack_count: expected %0d, actual %0d", exp_view.stack_count,
                      rsp_if.stack_count);
               error_count++;
            end
         end
      end
   end

   task automatic send_instr(input logic [OPCODE_BITS-1:0] op,
                             input logic [IMM_BITS-1:0] imm,
                             input logic [CELL_BITS-1:0] addr);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.opcode       <= op;
      req_if.immediate    <= imm;
      req_if.cell_address <= addr;
      do @(posedge clock); while (!req_if.ready);
      instr_sent++;
   endtask

   function automatic logic [IMM_BITS-1:0] pick_imm();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         4: return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CELL_BITS-1:0] pick_cell();
      if ($urandom_range(0, 99) < 60) return CELL_BITS'($urandom_range(0, 7));
      return CELL_BITS'($urandom_range(0, DATA_CELLS - 1));
   endfunction

   task automatic send_arith();
      send_instr($urandom_range(0, 1) ? OP_ADD : OP_SUB, $urandom(), CELL_BITS'($urandom()));
   endtask

   task automatic test_empty_stack();
      send_instr(OP_ST, $urandom(), 8'd0);
      send_instr(OP_ADD, $urandom(), CELL_BITS'($urandom()));
      send_instr(OP_SUB, $urandom(), CELL_BITS'($urandom()));
   endtask

   task automatic test_wrap_arith();
      send_instr(OP_LDC, 32'h7fff_ffff, CELL_BITS'($urandom()));
      send_instr(OP_SUB, $urandom(), CELL_BITS'($urandom()));
      send_instr(OP_LDC, 32'h8000_0000, CELL_BITS'($urandom()));
      send_instr(OP_ADD, $urandom(), CELL_BITS'($urandom()));
   endtask

   task automatic test_full_stack();
      logic [IMM_BITS-1:0] fill_vals [4] = '{32'h0, 32'hffff_ffff, 32'h5555_5555,
                                             32'haaaa_aaaa};
      send_instr(OP_LD, $urandom(), 8'd0);
      for (int i = 0; i < STACK_DEPTH - 2; i++) begin
         send_instr(OP_LDC, fill_vals[i % 4], CELL_BITS'($urandom()));
      end
      send_instr(OP_LDC, 32'h1234_5678, CELL_BITS'($urandom()));
      send_instr(OP_LD, $urandom(), 8'd255);
   endtask

   task automatic test_unused_opcodes();
      send_instr(3'd5, $urandom(), CELL_BITS'($urandom()));
      send_instr(3'd7, $urandom(), CELL_BITS'($urandom()));
      send_instr(OP_ST, $urandom(), 8'd255);
   endtask

   task automatic test_random_programs();
      int unsigned start;
      int unsigned done;
      int          n;
      logic [CELL_BITS-1:0] cell_sel;
      start = instr_sent;
      while (instr_sent - start < RANDOM_ITEMS) begin
         done = instr_sent - start;
         if (done >= 700 && done < 1100) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = IDLE_PCT;
            stall_pct = IDLE_PCT;
         end
         case ($urandom_range(0, 99)) inside
            [0:39]: begin
               // expression: push operands, fold them, sometimes store the result
               n = $urandom_range(2, 6);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 2) == 0) send_instr(OP_LD, $urandom(), pick_cell());
                  else send_instr(OP_LDC, pick_imm(), CELL_BITS'($urandom()));
               end
               for (int i = 1; i < n; i++) send_arith();
               if ($urandom_range(0, 1)) send_instr(OP_ST, $urandom(), pick_cell());
            end
            [40:59]: begin
               cell_sel = pick_cell();
               send_instr(OP_LDC, pick_imm(), CELL_BITS'($urandom()));
               send_instr(OP_ST, $urandom(), cell_sel);
               send_instr(OP_LD, $urandom(), cell_sel);
               send_instr(OP_LD, $urandom(), pick_cell());
               send_arith();
            end
            [60:69]: begin
               n = $urandom_range(10, 20);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 3) == 0) send_instr(OP_LD, $urandom(), pick_cell());
                  else send_instr(OP_LDC, pick_imm(), CELL_BITS'($urandom()));
               end
               n = $urandom_range(10, 20);
               for (int i = 0; i < n; i++) send_instr(OP_ST, $urandom(), pick_cell());
            end
            [70:84]: begin
               n = $urandom_range(1, 3);
               for (int i = 0; i < n; i++) send_arith();
            end
            default: begin
               n = $urandom_range(1, 4);
               for (int i = 0; i < n; i++) begin
                  send_instr(OPCODE_BITS'($urandom_range(0, 7)), $urandom(),
                             CELL_BITS'($urandom()));
               end
            end
         endcase
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.opcode       <= OP_LDC;
      req_if.immediate    <= '0;
      req_if.cell_address <= '0;
      shadow_depth = 0;
      instr_sent   = 0;
      error_count  = 0;
      idle_pct     = IDLE_PCT;
      stall_pct    = IDLE_PCT;
      for (int i = 0; i < DATA_CELLS; i++) shadow_mem[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stack();
      test_wrap_arith();
      test_full_stack();
      test_unused_opcodes();
      test_random_programs();

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (views_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/smc_pkg.sv
rtl/smc_if.sv
rtl/smc_data_mem.sv
rtl/stack_machine_core.sv
verif/tb_top.sv
